[sv/apt_pkg.sv]
// Shared widths, register and mode codes, and the coefficient set type for the
// affine point transform. No dependencies; every other file imports it.
`default_nettype none

package apt_pkg;

  // Field widths
  localparam int XW     = 32;        // coordinate and register field width
  localparam int KW     = 33;        // linear coefficient width (inverse quotients need 33)
  localparam int PW     = KW + XW;   // coefficient times coordinate
  localparam int OW     = 65;        // offset, determinant and numerator width
  localparam int SW     = OW + 2;    // sum of two products and an offset
  localparam int MAG_W  = OW - 1;    // divider magnitude width
  localparam int CFG_IW = 3;
  localparam int CFG_DW = 32;
  localparam int NPROD  = 6;         // products formed during precompute
  localparam int NQUO   = 6;         // quotients formed during precompute

  // Register indexes
  localparam logic [CFG_IW-1:0] REG_COEF_XX  = 3'd0;
  localparam logic [CFG_IW-1:0] REG_COEF_XY  = 3'd1;
  localparam logic [CFG_IW-1:0] REG_OFFSET_X = 3'd2;
  localparam logic [CFG_IW-1:0] REG_COEF_YX  = 3'd3;
  localparam logic [CFG_IW-1:0] REG_COEF_YY  = 3'd4;
  localparam logic [CFG_IW-1:0] REG_OFFSET_Y = 3'd5;
  localparam logic [CFG_IW-1:0] REG_MODE     = 3'd6;

  // Mode codes; the unused code behaves as full mode
  localparam logic [1:0] MODE_FULL    = 2'd0;
  localparam logic [1:0] MODE_LINEAR  = 2'd1;
  localparam logic [1:0] MODE_INVERSE = 2'd2;

  // Quotient slots in precompute order
  localparam logic [2:0] Q_YY  = 3'd0;
  localparam logic [2:0] Q_XY  = 3'd1;
  localparam logic [2:0] Q_YX  = 3'd2;
  localparam logic [2:0] Q_XX  = 3'd3;
  localparam logic [2:0] Q_NUMX = 3'd4;
  localparam logic [2:0] Q_NUMY = 3'd5;

  // Coefficients used by the point pipeline:
  //   rx = k0*x + k1*y + k2, ry = k3*x + k4*y + k5
  typedef struct packed {
    logic signed [KW-1:0] k0;
    logic signed [KW-1:0] k1;
    logic signed [OW-1:0] k2;
    logic signed [KW-1:0] k3;
    logic signed [KW-1:0] k4;
    logic signed [OW-1:0] k5;
    logic                 sing;
  } coef_set_t;

  typedef enum logic [2:0] {
    CS_IDLE,
    CS_MUL,
    CS_SUB,
    CS_DIV,
    CS_LOAD
  } coef_state_t;

endpackage

`default_nettype wire

[sv/apt_div.sv]
// Iterative signed divider, one quotient bit per cycle, truncating toward zero.
// Depends on apt_pkg for widths.
`default_nettype none

module apt_div
  import apt_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 flush,
  input  wire logic                 start,
  input  wire logic signed [OW-1:0] num,
  input  wire logic signed [OW-1:0] den,
  output logic                      done,
  output logic signed [OW-1:0]      quo
);

  localparam int CNT_W = $clog2(MAG_W);

  logic             run;
  logic [CNT_W-1:0] cnt;
  logic [MAG_W-1:0] rem;
  logic [MAG_W-1:0] nq;
  logic [MAG_W-1:0] dmag;
  logic             neg;

  logic [OW-1:0]    num_abs;
  logic [OW-1:0]    den_abs;
  logic [MAG_W:0]   shifted;
  logic             ge;
  logic [MAG_W:0]   diff;

  // Take magnitudes; both fit in MAG_W bits
  assign num_abs = num[OW-1] ? OW'(-num) : OW'(num);
  assign den_abs = den[OW-1] ? OW'(-den) : OW'(den);

  // One restoring step
  assign shifted = {rem, nq[MAG_W-1]};
  assign ge      = shifted >= {1'b0, dmag};
  assign diff    = shifted - {1'b0, dmag};

  // Apply the sign to the quotient magnitude
  assign quo = neg ? -$signed({1'b0, nq}) : $signed({1'b0, nq});

  always_ff @(posedge clk) begin
    if (rst || flush) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= run && (cnt == CNT_W'(MAG_W - 1));
      if (start) begin
        run <= 1'b1;
      end else if (run && (cnt == CNT_W'(MAG_W - 1))) begin
        run <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      cnt  <= '0;
      rem  <= '0;
      nq   <= num_abs[MAG_W-1:0];
      dmag <= den_abs[MAG_W-1:0];
      neg  <= num[OW-1] ^ den[OW-1];
    end else if (run) begin
      cnt <= cnt + CNT_W'(1);
      rem <= ge ? diff[MAG_W-1:0] : shifted[MAG_W-1:0];
      nq  <= {nq[MAG_W-2:0], ge};
    end
  end

endmodule

`default_nettype wire

[sv/apt_coef.sv]
// Configuration registers and the coefficient precompute sequencer: products,
// determinant, and the inverse quotients through apt_div. Depends on apt_pkg and apt_div.
`default_nettype none

module apt_coef
  import apt_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_we,
  input  wire logic [CFG_IW-1:0] cfg_index,
  input  wire logic [CFG_DW-1:0] cfg_data,
  output logic                   busy,
  output coef_set_t              coef
);

  logic signed [XW-1:0] coef_xx, coef_xy, offset_x;
  logic signed [XW-1:0] coef_yx, coef_yy, offset_y;
  logic [1:0]           mode;

  coef_state_t state, state_next;

  logic [2:0]             mul_step;
  logic [2:0]             div_idx;
  logic                   div_wait;
  logic signed [XW-1:0]   mul_a, mul_b;
  logic signed [2*XW-1:0] prod [NPROD];
  logic signed [OW-1:0]   det, num_x, num_y;
  logic signed [OW-1:0]   q [NQUO];
  logic signed [OW-1:0]   div_num;
  logic signed [OW-1:0]   div_quo;
  logic                   div_start;
  logic                   div_done;
  logic                   skip_div;

  // Register writes; an index beyond the list is ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      coef_xx  <= XW'(1);
      coef_xy  <= '0;
      offset_x <= '0;
      coef_yx  <= '0;
      coef_yy  <= XW'(1);
      offset_y <= '0;
      mode     <= MODE_FULL;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_COEF_XX:  coef_xx  <= cfg_data;
        REG_COEF_XY:  coef_xy  <= cfg_data;
        REG_OFFSET_X: offset_x <= cfg_data;
        REG_COEF_YX:  coef_yx  <= cfg_data;
        REG_COEF_YY:  coef_yy  <= cfg_data;
        REG_OFFSET_Y: offset_y <= cfg_data;
        REG_MODE:     mode     <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  assign skip_div = (mode != MODE_INVERSE) || (det == '0);

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      CS_IDLE: state_next = CS_IDLE;
      CS_MUL:  if (mul_step == 3'(NPROD - 1)) state_next = CS_SUB;
      CS_SUB:  state_next = CS_DIV;
      CS_DIV: begin
        if (skip_div) begin
          state_next = CS_LOAD;
        end else if (div_done && (div_idx == 3'(NQUO - 1))) begin
          state_next = CS_LOAD;
        end
      end
      CS_LOAD: state_next = CS_IDLE;
      default: state_next = CS_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    busy      = 1'b1;
    div_start = 1'b0;
    case (state)
      CS_IDLE: busy = 1'b0;
      CS_DIV:  div_start = !skip_div && !div_wait;
      default: ;
    endcase
  end

  // Restart the precompute after reset and after every write
  always_ff @(posedge clk) begin
    if (rst || cfg_we) begin
      state    <= CS_MUL;
      mul_step <= '0;
      div_idx  <= '0;
      div_wait <= 1'b0;
    end else begin
      state <= state_next;
      if (state == CS_MUL) mul_step <= mul_step + 3'd1;
      if (div_start) div_wait <= 1'b1;
      if (div_done) begin
        div_wait <= 1'b0;
        div_idx  <= div_idx + 3'd1;
      end
    end
  end

  // Select the product operands for this step
  always_comb begin
    case (mul_step)
      3'd0:    begin mul_a = coef_xx;  mul_b = coef_yy; end
      3'd1:    begin mul_a = coef_xy;  mul_b = coef_yx; end
      3'd2:    begin mul_a = coef_xy;  mul_b = offset_y; end
      3'd3:    begin mul_a = offset_x; mul_b = coef_yy; end
      3'd4:    begin mul_a = coef_xx;  mul_b = offset_y; end
      3'd5:    begin mul_a = offset_x; mul_b = coef_yx; end
      default: begin mul_a = coef_xx;  mul_b = coef_yy; end
    endcase
  end

  // One registered product per cycle
  always_ff @(posedge clk) begin
    if (state == CS_MUL) prod[mul_step] <= (2*XW)'(mul_a) * (2*XW)'(mul_b);
  end

  // Determinant and inverse offset numerators
  always_ff @(posedge clk) begin
    if (state == CS_SUB) begin
      det   <= OW'(prod[0]) - OW'(prod[1]);
      num_x <= OW'(prod[2]) - OW'(prod[3]);
      num_y <= OW'(prod[4]) - OW'(prod[5]);
    end
  end

  // Pick the dividend for the current quotient
  always_comb begin
    case (div_idx)
      Q_YY:    div_num = OW'(coef_yy);
      Q_XY:    div_num = OW'(coef_xy);
      Q_YX:    div_num = OW'(coef_yx);
      Q_XX:    div_num = OW'(coef_xx);
      Q_NUMX:  div_num = num_x;
      Q_NUMY:  div_num = num_y;
      default: div_num = num_y;
    endcase
  end

  apt_div u_div (
    .clk   (clk),
    .rst   (rst),
    .flush (cfg_we),
    .start (div_start),
    .num   (div_num),
    .den   (det),
    .done  (div_done),
    .quo   (div_quo)
  );

  always_ff @(posedge clk) begin
    if (div_done) q[div_idx] <= div_quo;
  end

  // Load the coefficient set for the current mode
  always_ff @(posedge clk) begin
    if (state == CS_LOAD) begin
      case (mode)
        MODE_INVERSE: begin
          coef.k0   <= q[Q_YY][KW-1:0];
          coef.k1   <= -q[Q_XY][KW-1:0];
          coef.k2   <= q[Q_NUMX];
          coef.k3   <= -q[Q_YX][KW-1:0];
          coef.k4   <= q[Q_XX][KW-1:0];
          coef.k5   <= -q[Q_NUMY];
          coef.sing <= (det == '0);
        end
        MODE_LINEAR: begin
          coef.k0   <= KW'(coef_xx);
          coef.k1   <= KW'(coef_xy);
          coef.k2   <= '0;
          coef.k3   <= KW'(coef_yx);
          coef.k4   <= KW'(coef_yy);
          coef.k5   <= '0;
          coef.sing <= 1'b0;
        end
        default: begin
          coef.k0   <= KW'(coef_xx);
          coef.k1   <= KW'(coef_xy);
          coef.k2   <= OW'(offset_x);
          coef.k3   <= KW'(coef_yx);
          coef.k4   <= KW'(coef_yy);
          coef.k5   <= OW'(offset_y);
          coef.sing <= 1'b0;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

[sv/apt_datapath.sv]
// Three-stage point pipeline: multiply, sum, saturate into the output register.
// Depends on apt_pkg for widths and the coefficient set type.
`default_nettype none

module apt_datapath
  import apt_pkg::*;
#(
  parameter int COORD_WIDTH = 32
)
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 hold,
  input  wire coef_set_t            coef,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic signed [XW-1:0] in_x,
  input  wire logic signed [XW-1:0] in_y,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic signed [XW-1:0]      out_x,
  output logic signed [XW-1:0]      out_y,
  output logic                      overflow,
  output logic                      singular
);

  localparam int SAT_W = (COORD_WIDTH > XW) ? XW : COORD_WIDTH;
  localparam logic signed [SW-1:0] SAT_MAX = (SW'(1) <<< (SAT_W - 1)) - SW'(1);
  localparam logic signed [SW-1:0] SAT_MIN = -SAT_MAX - SW'(1);

  logic v1, v2, v3;
  logic rdy1, rdy2, rdy3;
  logic accept;

  logic signed [PW-1:0] m_xx, m_xy, m_yx, m_yy;
  logic signed [PW-1:0] p_xx, p_xy, p_yx, p_yy;
  logic signed [SW-1:0] s_x, s_y;

  logic hi_x, lo_x, hi_y, lo_y;
  logic signed [XW-1:0] sat_x, sat_y;

  // Each stage moves on when the one after it has room
  assign rdy3     = !v3 || out_ready;
  assign rdy2     = !v2 || rdy3;
  assign rdy1     = !v1 || rdy2;
  assign in_ready = rdy1 && !hold;
  assign accept   = in_valid && in_ready;
  assign out_valid = v3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (rdy1) v1 <= accept;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
    end
  end

  // Stage 1: four coefficient products
  assign m_xx = PW'(coef.k0) * PW'(in_x);
  assign m_xy = PW'(coef.k1) * PW'(in_y);
  assign m_yx = PW'(coef.k3) * PW'(in_x);
  assign m_yy = PW'(coef.k4) * PW'(in_y);

  always_ff @(posedge clk) begin
    if (accept) begin
      p_xx <= m_xx;
      p_xy <= m_xy;
      p_yx <= m_yx;
      p_yy <= m_yy;
    end
  end

  // Stage 2: exact sums with the offsets
  always_ff @(posedge clk) begin
    if (v1 && rdy2) begin
      s_x <= SW'(p_xx) + SW'(p_xy) + SW'($signed(coef.k2));
      s_y <= SW'(p_yx) + SW'(p_yy) + SW'($signed(coef.k5));
    end
  end

  // Stage 3: clamp to the coordinate range
  assign hi_x = s_x > SAT_MAX;
  assign lo_x = s_x < SAT_MIN;
  assign hi_y = s_y > SAT_MAX;
  assign lo_y = s_y < SAT_MIN;

  assign sat_x = hi_x ? SAT_MAX[XW-1:0] : (lo_x ? SAT_MIN[XW-1:0] : s_x[XW-1:0]);
  assign sat_y = hi_y ? SAT_MAX[XW-1:0] : (lo_y ? SAT_MIN[XW-1:0] : s_y[XW-1:0]);

  // Output register; a singular matrix forces zeros
  always_ff @(posedge clk) begin
    if (v2 && rdy3) begin
      if (coef.sing) begin
        out_x    <= '0;
        out_y    <= '0;
        overflow <= 1'b0;
        singular <= 1'b1;
      end else begin
        out_x    <= sat_x;
        out_y    <= sat_y;
        overflow <= hi_x || lo_x || hi_y || lo_y;
        singular <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

[sv/affine_point_transform.sv]
// Integer 2D affine point transform; top level over apt_coef and apt_datapath.
// An accepted input passes the product, sum and output registers before output
// valid; one point per cycle while out_ready allows it. After reset and after
// every register write the input is held off while the coefficients are rebuilt;
// inverse mode with a nonsingular matrix adds six divisions in the shared divider.
// Reset (synchronous) loads the identity matrix in full mode and empties the pipe.
`default_nettype none

module affine_point_transform
  import apt_pkg::*;
#(
  parameter int COORD_WIDTH = 32
)
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IW-1:0]    cfg_index,
  input  wire logic [CFG_DW-1:0]    cfg_data,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic signed [XW-1:0] in_x,
  input  wire logic signed [XW-1:0] in_y,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic signed [XW-1:0]      out_x,
  output logic signed [XW-1:0]      out_y,
  output logic                      overflow,
  output logic                      singular
);

  logic      busy;
  coef_set_t coef;

  apt_coef u_coef (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .busy      (busy),
    .coef      (coef)
  );

  apt_datapath #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .hold      (busy),
    .coef      (coef),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_x      (in_x),
    .in_y      (in_y),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_x     (out_x),
    .out_y     (out_y),
    .overflow  (overflow),
    .singular  (singular)
  );

endmodule

`default_nettype wire
